// File: src/frlw_pkg.sv
// Shared types, codes and the CRC-16 byte update for the frame receiver and link watchdog.
`timescale 1ns / 1ps
`default_nettype none

package frlw_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTROL_COMMAND  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_OK       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_DEGRADED = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_LOST     = 3'd4;

    localparam logic [7:0]  START_BYTE_RST       = 8'd250;
    localparam logic [7:0]  CONTROL_COMMAND_RST  = 8'd0;
    localparam logic [15:0] TIMEOUT_OK_RST       = 16'd200;
    localparam logic [15:0] TIMEOUT_DEGRADED_RST = 16'd500;
    localparam logic [15:0] TIMEOUT_LOST_RST     = 16'd1000;

    typedef enum logic [2:0] {
        LINK_INIT      = 3'd0,
        LINK_OK        = 3'd1,
        LINK_DEGRADED  = 3'd2,
        LINK_LOST      = 3'd3,
        LINK_EMERGENCY = 3'd4
    } link_mode_t;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_ACK   = 3'd1,
        EV_OTHER = 3'd2,
        EV_CRC   = 3'd3,
        EV_ABORT = 3'd4
    } frame_event_t;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  control_command;
        logic [15:0] timeout_ok;
        logic [15:0] timeout_degraded;
        logic [15:0] timeout_lost;
    } cfg_regs_t;

    typedef struct packed {
        frame_event_t evt;
        logic         ack;
    } dfr_status_t;

    // MSB-first CRC-16, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int j = 0; j < 8; j++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/frlw_deframer.sv
// Byte deframer: start, length, command, payload and CRC-16 check.
`timescale 1ns / 1ps
`default_nettype none

module frlw_deframer import frlw_pkg::*; #(
    parameter int MAX_FRAME = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic [7:0]  byte_value,
    input  wire cfg_regs_t   cfg,
    output dfr_status_t      status
);

    localparam logic [7:0] MaxFrameB = 8'(MAX_FRAME);
    localparam logic [8:0] MaxFrameW = 9'(MAX_FRAME);

    logic        active_reg, active_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] recent_reg, recent_next;

    logic [7:0]  cnt1;
    logic [15:0] recent_shift;
    logic [7:0]  len_eff;
    logic [7:0]  cmd_eff;
    logic [8:0]  crc_end;
    logic [8:0]  frame_end;

    assign cnt1         = count_reg + 8'd1;
    assign recent_shift = {byte_value, recent_reg[15:8]};
    assign len_eff      = (cnt1 == 8'd2) ? byte_value : length_reg;
    assign cmd_eff      = (cnt1 == 8'd3) ? byte_value : command_reg;
    assign crc_end      = {1'b0, len_eff} + 9'd3;
    assign frame_end    = {1'b0, len_eff} + 9'd5;

    always_comb
    begin
        active_next  = active_reg;
        count_next   = count_reg;
        length_next  = length_reg;
        command_next = command_reg;
        crc_next     = crc_reg;
        recent_next  = recent_reg;
        status.evt   = EV_NONE;
        status.ack   = 1'b0;

        priority if (!active_reg)
        begin
            if (byte_value == cfg.start_byte)
            begin
                active_next = 1'b1;
                count_next  = 8'd1;
                crc_next    = crc16_byte(CRC_INIT, byte_value);
                recent_next = recent_shift;
            end
        end
        else if (count_reg >= MaxFrameB)
        begin
            // overflow: byte dropped
            active_next = 1'b0;
            count_next  = 8'd0;
            status.evt  = EV_ABORT;
        end
        else if ((cnt1 == 8'd2) && (({1'b0, byte_value} + 9'd5) > MaxFrameW))
        begin
            length_next = byte_value;
            recent_next = recent_shift;
            active_next = 1'b0;
            count_next  = 8'd0;
            status.evt  = EV_ABORT;
        end
        else
        begin
            count_next   = cnt1;
            recent_next  = recent_shift;
            length_next  = len_eff;
            command_next = cmd_eff;
            if ({1'b0, cnt1} <= crc_end)
                crc_next = crc16_byte(crc_reg, byte_value);
            if ({1'b0, cnt1} >= frame_end)
            begin
                active_next = 1'b0;
                count_next  = 8'd0;
                if (recent_shift != crc_next)
                    status.evt = EV_CRC;
                else if (cmd_eff == cfg.control_command)
                begin
                    status.evt = EV_ACK;
                    status.ack = en;
                end
                else
                    status.evt = EV_OTHER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            count_reg   <= 8'd0;
            length_reg  <= 8'd0;
            command_reg <= 8'd0;
            crc_reg     <= CRC_INIT;
            recent_reg  <= 16'd0;
        end
        else if (en)
        begin
            active_reg  <= active_next;
            count_reg   <= count_next;
            length_reg  <= length_next;
            command_reg <= command_next;
            crc_reg     <= crc_next;
            recent_reg  <= recent_next;
        end
    end

endmodule

`default_nettype wire

// File: src/frlw_watchdog.sv
// Link watchdog: acknowledge time and the INIT/OK/DEGRADED/LOST/EMERGENCY state machine.
`timescale 1ns / 1ps
`default_nettype none

module frlw_watchdog import frlw_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        tick,
    input  wire logic        ack,
    input  wire logic [31:0] now_ms,
    input  wire cfg_regs_t   cfg,
    output link_mode_t       link_state,
    output logic             drive_off
);

    link_mode_t  mode_reg, mode_next;
    logic [31:0] ack_time_reg;
    logic [31:0] elapsed;

    // wraps modulo 2^32
    assign elapsed = now_ms - ack_time_reg;

    always_comb
    begin
        mode_next = mode_reg;
        drive_off = 1'b0;
        if (tick)
        begin
            unique case (mode_reg)
                LINK_OK:
                    if (elapsed > {16'd0, cfg.timeout_ok})
                        mode_next = LINK_DEGRADED;
                LINK_DEGRADED:
                    if (elapsed > {16'd0, cfg.timeout_degraded})
                        mode_next = LINK_LOST;
                LINK_LOST:
                    if (elapsed > {16'd0, cfg.timeout_lost})
                    begin
                        mode_next = LINK_EMERGENCY;
                        drive_off = 1'b1;
                    end
                default:
                    mode_next = mode_reg;
            endcase
        end
        else if (ack && (mode_reg != LINK_EMERGENCY))
            mode_next = LINK_OK;
    end

    assign link_state = mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= LINK_INIT;
            ack_time_reg <= 32'd0;
        end
        else if (en)
        begin
            mode_reg <= mode_next;
            if (ack)
                ack_time_reg <= now_ms;
        end
    end

endmodule

`default_nettype wire

// File: src/frame_receiver_link_watchdog_core.sv
// Top level: input register, deframer, watchdog, output register and configuration registers.
//
// Usage:
//   s_axis carries one item per transfer: tuser is the kind (0 received byte,
//   1 watchdog tick), tdata holds the byte and the 32-bit millisecond time.
//   m_axis returns exactly one result per input item, in order: link state
//   after the item, frame event and the drive-off flag.
//   cfg_* writes one configuration register per transfer; cfg_ready is
//   always high. Write only while no item is in flight.
// Data path and throughput:
//   The input register takes the item at the transfer edge; one pass through
//   the deframer and watchdog then loads the output register. One item per
//   cycle is sustained while the output is not stalled; the per-item frame and
//   link state is updated in that pass.
// Reset (rst_n low, asynchronous) empties both registers, clears the frame
//   state, sets the link to INIT and loads the default configuration.
// Stalls: when m_axis_tready is low the output register holds; one more item
//   waits in the input register, after which s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module frame_receiver_link_watchdog_core import frlw_pkg::*; #(
    parameter int MAX_FRAME = 64
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [39:0]            s_axis_tdata,  // byte_value[7:0], now_ms[39:8]
    input  wire logic                   s_axis_tuser,  // action
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [7:0]                  m_axis_tdata,  // link_state[2:0], frame_event[5:3],
                                                       // drive_off[6], zero[7]
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_regs_t   cfg_reg;

    logic        in_valid_reg;
    logic        in_action_reg;
    logic [7:0]  in_byte_reg;
    logic [31:0] in_now_reg;

    logic        out_valid_reg;
    logic [7:0]  out_data_reg;

    logic        proc_fire;
    dfr_status_t dfr_status;
    link_mode_t  link_state;
    logic        drive_off;
    frame_event_t result_evt;

    assign proc_fire     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte       <= START_BYTE_RST;
            cfg_reg.control_command  <= CONTROL_COMMAND_RST;
            cfg_reg.timeout_ok       <= TIMEOUT_OK_RST;
            cfg_reg.timeout_degraded <= TIMEOUT_DEGRADED_RST;
            cfg_reg.timeout_lost     <= TIMEOUT_LOST_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_START_BYTE:       cfg_reg.start_byte       <= cfg_data[7:0];
                CFG_CONTROL_COMMAND:  cfg_reg.control_command  <= cfg_data[7:0];
                CFG_TIMEOUT_OK:       cfg_reg.timeout_ok       <= cfg_data;
                CFG_TIMEOUT_DEGRADED: cfg_reg.timeout_degraded <= cfg_data;
                CFG_TIMEOUT_LOST:     cfg_reg.timeout_lost     <= cfg_data;
                default:              ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_action_reg <= s_axis_tuser;
            in_byte_reg   <= s_axis_tdata[7:0];
            in_now_reg    <= s_axis_tdata[39:8];
        end
    end

    frlw_deframer #(
        .MAX_FRAME (MAX_FRAME)
    ) u_deframer (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (proc_fire && !in_action_reg),
        .byte_value (in_byte_reg),
        .cfg        (cfg_reg),
        .status     (dfr_status)
    );

    frlw_watchdog u_watchdog (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (proc_fire),
        .tick       (in_action_reg),
        .ack        (dfr_status.ack && !in_action_reg),
        .now_ms     (in_now_reg),
        .cfg        (cfg_reg),
        .link_state (link_state),
        .drive_off  (drive_off)
    );

    // a tick never carries a frame event
    assign result_evt = in_action_reg ? EV_NONE : dfr_status.evt;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc_fire)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
            out_data_reg <= {1'b0, drive_off, result_evt, link_state};
    end

`ifndef SYNTH
    a_drive_off_means_emergency: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[6] |-> out_data_reg[2:0] == LINK_EMERGENCY)
        else $error("drive_off without EMERGENCY");

    a_no_event_with_drive_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[6] |-> out_data_reg[5:3] == EV_NONE)
        else $error("frame event reported on a tick result");

    a_input_held_until_processed: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !proc_fire |=> in_valid_reg && $stable(in_now_reg)
            && $stable(in_byte_reg) && $stable(in_action_reg))
        else $error("pending input item overwritten");

    a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result dropped or changed");
`endif

endmodule

`default_nettype wire
